[rtl/interacting_exclusion_ring_update_macros.svh]
// ----------------------------------------------------------------------------
// interacting exclusion ring update: assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef INTERACTING_EXCLUSION_RING_UPDATE_MACROS_SVH
`define INTERACTING_EXCLUSION_RING_UPDATE_MACROS_SVH

// same-cycle implication
`define IERU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ieru assertion failed");

// next-cycle implication
`define IERU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ieru assertion failed");

`endif

[rtl/ieru_pkg.sv]
// ----------------------------------------------------------------------------
// ieru_pkg
// shared constants, codes and types of the exclusion ring update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ieru_pkg;

  localparam int RING_SITES   = 128;
  localparam int MONITOR_SITE = 63;
  localparam int SITE_W       = $clog2(RING_SITES);

  localparam int OP_W       = 2;
  localparam int SITE_IDX_W = 7;
  localparam int RAND_W     = 16;
  localparam int THR_W      = 17;
  localparam int CNT_W      = 32;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(655);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  typedef enum logic [OP_W-1:0] {
    OP_MOVE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_BARE    = 2'd0,
    REG_BINDING = 2'd1,
    REG_RELEASE = 2'd2,
    REG_WARMUP  = 2'd3
  } reg_addr_t;

  typedef struct packed {
    logic [THR_W-1:0] bare_thr;
    logic [THR_W-1:0] bind_thr;
    logic [THR_W-1:0] rel_thr;
    logic [CNT_W-1:0] warmup;
  } cfg_t;

endpackage

[rtl/ieru_if.sv]
// ----------------------------------------------------------------------------
// ieru channel interfaces
// valid/ready channels for update items and result items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ieru_req_if;
  logic                              valid;
  logic                              ready;
  logic [ieru_pkg::OP_W-1:0]         opcode;
  logic [ieru_pkg::SITE_IDX_W-1:0]   site_index;
  logic [ieru_pkg::RAND_W-1:0]       random_value;
  logic                              occupy_value;

  modport source (output valid, output opcode, output site_index, output random_value,
                  output occupy_value, input ready);
  modport sink (input valid, input opcode, input site_index, input random_value,
                input occupy_value, output ready);
endinterface

interface ieru_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hopped;
  logic [ieru_pkg::CNT_W-1:0]  current_count;
  logic                        site_occupied;

  modport source (output valid, output hopped, output current_count,
                  output site_occupied, input ready);
  modport sink (input valid, input hopped, input current_count,
                input site_occupied, output ready);
endinterface

[rtl/interacting_exclusion_ring_update.sv]
// ----------------------------------------------------------------------------
// interacting_exclusion_ring_update
// random-sequential update of an interacting exclusion ring lattice
//
// usage:
//   req carries one item per handshake: opcode (move, write site, clear),
//   site_index, random_value and occupy_value. rsp returns exactly one item
//   per request: hopped, current_count (monitored hop counter after the item)
//   and site_occupied (named site after the item).
//   an item is held in an input register, evaluated against the lattice
//   flops in one pass and written to the result register; lattice and
//   counters update at that same edge.
//   an accepted item passes the input register, then the result register,
//   before it shows on rsp. throughput: one item per cycle while rsp takes
//   results, set by the single-pass lattice update in the flop ring.
//   receiver stall: the result register holds, the input register fills,
//   then req.ready drops; nothing is lost or repeated.
//   reset (rst, synchronous): lattice empty, counters zero, thresholds 655,
//   warm-up zero, both channels empty. the user must write thresholds and
//   warm-up at 4*index over apb only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "interacting_exclusion_ring_update_macros.svh"

module interacting_exclusion_ring_update (
  input  logic                          clk,
  input  logic                          rst,
  ieru_req_if.sink                      req,
  ieru_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ieru_pkg::ADDR_W-1:0]   paddr,
  input  logic [ieru_pkg::DATA_W-1:0]   pwdata,
  output logic [ieru_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int SW = ieru_pkg::SITE_W;

  ieru_pkg::cfg_t cfg;

  // input register
  logic                              s1_valid;
  logic [ieru_pkg::OP_W-1:0]         s1_op;
  logic [ieru_pkg::SITE_IDX_W-1:0]   s1_site;
  logic [ieru_pkg::RAND_W-1:0]       s1_rnd;
  logic                              s1_wval;

  // result register
  logic                              out_valid;
  logic                              out_hopped;
  logic [ieru_pkg::CNT_W-1:0]        out_count;
  logic                              out_occ;

  // lattice and counters
  logic [ieru_pkg::RING_SITES-1:0]   occ;
  logic [ieru_pkg::RING_SITES-1:0]   occ_next;
  logic [ieru_pkg::CNT_W-1:0]        hop_current;
  logic [ieru_pkg::CNT_W-1:0]        hop_current_next;
  logic [ieru_pkg::CNT_W-1:0]        move_count;
  logic [ieru_pkg::CNT_W-1:0]        move_count_next;

  logic                              s1_adv;
  logic                              site_ok;
  logic [SW-1:0]                     idx;
  logic [SW-1:0]                     nx_idx;
  logic [SW-1:0]                     nn_idx;
  logic [SW-1:0]                     pv_idx;
  logic                              occ_s;
  logic                              occ_nx;
  logic                              occ_nn;
  logic                              occ_pv;
  logic [ieru_pkg::THR_W-1:0]        thr;
  logic                              is_move;
  logic                              is_write;
  logic                              is_clear;
  logic                              can_hop;
  logic                              count_hop;
  logic                              res_occ;
  logic                              hop_fire;
  logic                              clr_fire;

  ieru_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;

  assign rsp.valid         = out_valid;
  assign rsp.hopped        = out_hopped;
  assign rsp.current_count = out_count;
  assign rsp.site_occupied = out_occ;

  // neighbor addressing with wrap
  assign site_ok = 32'(s1_site) < 32'(ieru_pkg::RING_SITES);
  assign idx     = SW'(s1_site);
  assign nx_idx  = (idx == SW'(ieru_pkg::RING_SITES - 1)) ? '0 : idx + 1'b1;
  assign nn_idx  = (nx_idx == SW'(ieru_pkg::RING_SITES - 1)) ? '0 : nx_idx + 1'b1;
  assign pv_idx  = (idx == '0) ? SW'(ieru_pkg::RING_SITES - 1) : idx - 1'b1;

  assign occ_s  = occ[idx];
  assign occ_nx = occ[nx_idx];
  assign occ_nn = occ[nn_idx];
  assign occ_pv = occ[pv_idx];

  assign is_move  = s1_op == ieru_pkg::OP_MOVE;
  assign is_write = s1_op == ieru_pkg::OP_WRITE;
  assign is_clear = s1_op == ieru_pkg::OP_CLEAR;

  always_comb begin
    priority if (occ_pv == occ_nn) begin
      thr = cfg.bare_thr;
    end else if (occ_pv) begin
      thr = cfg.rel_thr;
    end else begin
      thr = cfg.bind_thr;
    end
  end

  assign can_hop   = is_move && site_ok && occ_s && !occ_nx &&
                     ({1'b0, s1_rnd} < thr);
  assign count_hop = can_hop && (idx == SW'(ieru_pkg::MONITOR_SITE)) &&
                     (move_count >= cfg.warmup);
  assign hop_fire  = s1_adv && can_hop;
  assign clr_fire  = s1_adv && is_clear;

  // effect of the item in the input register
  always_comb begin
    occ_next         = occ;
    hop_current_next = hop_current;
    move_count_next  = move_count;
    if (is_clear) begin
      occ_next         = '0;
      hop_current_next = '0;
      move_count_next  = '0;
    end else if (is_move) begin
      if (can_hop) begin
        occ_next[idx]    = 1'b0;
        occ_next[nx_idx] = 1'b1;
      end
      if (count_hop && hop_current != ieru_pkg::CNT_MAX) begin
        hop_current_next = hop_current + 1'b1;
      end
      if (move_count != ieru_pkg::CNT_MAX) begin
        move_count_next = move_count + 1'b1;
      end
    end else if (is_write && site_ok) begin
      occ_next[idx] = s1_wval;
    end
  end

  assign res_occ = site_ok ? occ_next[idx] : 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_op   <= req.opcode;
      s1_site <= req.site_index;
      s1_rnd  <= req.random_value;
      s1_wval <= req.occupy_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ         <= '0;
      hop_current <= '0;
      move_count  <= '0;
    end else if (s1_adv) begin
      occ         <= occ_next;
      hop_current <= hop_current_next;
      move_count  <= move_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_hopped <= can_hop;
      out_count  <= hop_current_next;
      out_occ    <= res_occ;
    end
  end

  // a hop moves a particle, never creates or removes one
  `IERU_ASSERT_NEXT(a_hop_conserves, hop_fire, $countones(occ) == $past($countones(occ)))
  // clear empties the lattice and both counters
  `IERU_ASSERT_NEXT(a_clear_empties, clr_fire,
                    (occ == '0) && (hop_current == '0) && (move_count == '0))
  // the monitored counter only changes on a hop or a clear
  `IERU_ASSERT_IMPL(a_count_source,
                    (hop_current != $past(hop_current)) && !$past(clr_fire),
                    $past(hop_fire))
  // an item leaving the input register always shows a result next cycle
  `IERU_ASSERT_NEXT(a_result_follows, s1_adv, out_valid)

endmodule

[rtl/ieru_cfg.sv]
// ----------------------------------------------------------------------------
// ieru_cfg
// apb register file for hop thresholds and warm-up move count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ieru_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ieru_pkg::ADDR_W-1:0]   paddr,
  input  logic [ieru_pkg::DATA_W-1:0]   pwdata,
  output logic [ieru_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output ieru_pkg::cfg_t                cfg
);

  logic                reg_wr;
  ieru_pkg::reg_addr_t reg_sel;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite;
  assign reg_sel = ieru_pkg::reg_addr_t'(paddr[ieru_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bare_thr <= ieru_pkg::THR_RESET;
      cfg.bind_thr <= ieru_pkg::THR_RESET;
      cfg.rel_thr  <= ieru_pkg::THR_RESET;
      cfg.warmup   <= '0;
    end else if (reg_wr) begin
      unique case (reg_sel)
        ieru_pkg::REG_BARE:    cfg.bare_thr <= pwdata[ieru_pkg::THR_W-1:0];
        ieru_pkg::REG_BINDING: cfg.bind_thr <= pwdata[ieru_pkg::THR_W-1:0];
        ieru_pkg::REG_RELEASE: cfg.rel_thr  <= pwdata[ieru_pkg::THR_W-1:0];
        ieru_pkg::REG_WARMUP:  cfg.warmup   <= pwdata[ieru_pkg::CNT_W-1:0];
        default:               cfg.warmup   <= cfg.warmup;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ieru_pkg::REG_BARE:    prdata = ieru_pkg::DATA_W'(cfg.bare_thr);
      ieru_pkg::REG_BINDING: prdata = ieru_pkg::DATA_W'(cfg.bind_thr);
      ieru_pkg::REG_RELEASE: prdata = ieru_pkg::DATA_W'(cfg.rel_thr);
      ieru_pkg::REG_WARMUP:  prdata = ieru_pkg::DATA_W'(cfg.warmup);
      default:               prdata = '0;
    endcase
  end

endmodule
